// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL; isu_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/isu_pkg.sv -----
package isu_pkg;

  localparam int SITE_W        = 10;
  localparam int LEN_W         = 11;
  localparam int DRAW_W        = 16;
  localparam int DRAW_BITS     = 16;
  localparam int LIMIT_W       = 17;
  localparam int LIMIT_REG_W   = 3 * LIMIT_W;
  localparam int TOT_W         = 12;
  localparam int CFG_DATA_W    = LIMIT_REG_W;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_SITES_DEF = 1024;
  localparam int LEN_RESET_DEF = 1024;
  localparam int LEN_MIN       = 3;
  localparam int LEN_MAX       = (1 << LEN_W) - 1;

  localparam logic [DRAW_W-1:0] DRAW_MASK =
    (DRAW_BITS >= DRAW_W) ? {DRAW_W{1'b1}} : DRAW_W'((1 << DRAW_BITS) - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLER_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_LIMITS_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_LIMITS_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_BATH_LIMITS = 3'd4;

  // Item commands and sampler modes.
  localparam logic CMD_WRITE       = 1'b0;
  localparam logic CMD_TRIAL       = 1'b1;
  localparam logic MODE_METROPOLIS = 1'b0;
  localparam logic MODE_GIBBS      = 1'b1;

  // Number of up neighbours, which selects the threshold slot.
  localparam logic [1:0] NSUM_NEG  = 2'd0;
  localparam logic [1:0] NSUM_ZERO = 2'd1;
  localparam logic [1:0] NSUM_POS  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [SITE_W-1:0] site;
    logic              spin_value;
    logic [DRAW_W-1:0] uniform_draw;
  } in_item_t;

  typedef struct packed {
    logic                    new_spin;
    logic                    accepted;
    logic signed [TOT_W-1:0] bond_total;
    logic signed [TOT_W-1:0] magnet_total;
    logic                    bad_site;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic commit;
    logic clr_start;
    logic clr_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ring_wr;
    logic clr_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/isu_ram.sv -----
module isu_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] ra_addr,
  output logic [WIDTH-1:0]  ra_data,
  input  logic [ADDR_W-1:0] rb_addr,
  output logic [WIDTH-1:0]  rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ----- hw/rtl/isu_ctrl.sv -----
`include "assert_macros.svh"

module isu_ctrl
  import isu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sta,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sta.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // The result register must be free before the step commits.
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    // A new ring length restarts the sweep that sets every spin up.
    if (sta.ring_wr) begin
      cmd.clr_start = 1'b1;
      cmd.clr_step  = 1'b0;
      state_nxt     = ST_CLEAR;
    end
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  `ASSERT_SYNC(a_fetch_after_accept, clk, rst_n, state_r == ST_FETCH |-> $past(state_r == ST_IDLE && in_valid), "fetch without an accepted transaction")
  `ASSERT_SYNC(a_ring_write_clears, clk, rst_n, sta.ring_wr |=> state_r == ST_CLEAR, "ring length write did not start a clear")
  `ASSERT_SYNC(a_exec_free_commits, clk, rst_n, (state_r == ST_EXEC && !out_valid_r && !sta.ring_wr) |=> (state_r == ST_IDLE && out_valid_r), "result not delivered to a free output register")
  `ASSERT_NEVER(a_no_commit_in_clear, clk, rst_n, state_r == ST_CLEAR && (cmd.commit || cmd.load), "item work during clear")

endmodule

// ----- hw/rtl/isu_dp.sv -----
module isu_dp
  import isu_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sta
);

  localparam int AW        = $clog2(MAX_SITES);
  localparam int LEN_CAP_I = (MAX_SITES > LEN_MAX) ? LEN_MAX : MAX_SITES;
  localparam int LEN_RST_I = (MAX_SITES < LEN_RESET_DEF) ? MAX_SITES : LEN_RESET_DEF;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(LEN_RST_I);
  localparam logic [LEN_W-1:0] LEN_LOW = LEN_W'(LEN_MIN);
  localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_SITES - 1);
  localparam logic signed [TOT_W-1:0] TWO  = TOT_W'(2);
  localparam logic signed [TOT_W-1:0] FOUR = TOT_W'(4);

  // Configuration and running totals.
  logic                    mode_r, mode_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [LIMIT_REG_W-1:0]  lim_up_r, lim_up_nxt;
  logic [LIMIT_REG_W-1:0]  lim_dn_r, lim_dn_nxt;
  logic [LIMIT_REG_W-1:0]  heat_r, heat_nxt;
  logic signed [TOT_W-1:0] bond_r, bond_nxt;
  logic signed [TOT_W-1:0] mag_r, mag_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;

  // Item held while it is worked on.
  in_item_t   item_r;
  logic [AW-1:0] site_addr_r;
  logic       bad_r;
  logic       nl_r;
  logic       nr_r;
  out_item_t  out_r, out_nxt;

  logic [LEN_W-1:0] site_ext;
  logic [LEN_W-1:0] left_l;
  logic [LEN_W-1:0] right_l;
  logic [LEN_W-1:0] right_inc;
  logic             bad_in;
  logic [LEN_W-1:0] cfg_len;
  logic [LEN_W-1:0] len_sat;

  logic             we;
  logic [AW-1:0]    waddr;
  logic             wdata;
  logic [AW-1:0]    ra_addr;
  logic [AW-1:0]    rb_addr;
  logic             ra_data;
  logic             rb_data;

  logic                   cur;
  logic [1:0]             slot;
  logic [LIMIT_REG_W-1:0] lim_sel;
  logic [LIMIT_W-1:0]     thr;
  logic [LIMIT_W-1:0]     draw;
  logic                   hit;
  logic                   new_bit;
  logic                   acc;
  logic                   changed;
  logic signed [TOT_W-1:0] mag_step;
  logic signed [TOT_W-1:0] bond_step;
  logic signed [TOT_W-1:0] bond_new;
  logic signed [TOT_W-1:0] mag_new;

  // Neighbour addresses wrap around the ring.
  always_comb begin
    site_ext  = {1'b0, in_item.site};
    bad_in    = (site_ext >= len_r);
    right_inc = site_ext + LEN_W'(1);
    if (in_item.site == '0) begin
      left_l = len_r - LEN_W'(1);
    end else begin
      left_l = site_ext - LEN_W'(1);
    end
    if (right_inc >= len_r) begin
      right_l = '0;
    end else begin
      right_l = right_inc;
    end
  end

  always_comb begin
    cfg_len = cfg_data[LEN_W-1:0];
    if (cfg_len < LEN_LOW) begin
      len_sat = LEN_LOW;
    end else if (cfg_len > LEN_CAP) begin
      len_sat = LEN_CAP;
    end else begin
      len_sat = cfg_len;
    end
  end

  assign sta.ring_wr  = cfg_we && (cfg_index == REG_RING_LENGTH);
  assign sta.clr_last = (clr_cnt_r == CLR_LAST);

  // Step evaluation, valid in the execute cycle.
  always_comb begin
    cur  = ra_data;
    slot = {1'b0, nl_r} + {1'b0, nr_r};
    if (mode_r == MODE_GIBBS) begin
      lim_sel = heat_r;
    end else if (cur) begin
      lim_sel = lim_up_r;
    end else begin
      lim_sel = lim_dn_r;
    end
    case (slot)
      NSUM_NEG:  thr = lim_sel[LIMIT_W-1:0];
      NSUM_ZERO: thr = lim_sel[2*LIMIT_W-1:LIMIT_W];
      NSUM_POS:  thr = lim_sel[3*LIMIT_W-1:2*LIMIT_W];
      default:   thr = '0;
    endcase
    draw = {1'b0, item_r.uniform_draw & DRAW_MASK};
    hit  = (draw < thr);
    case (item_r.cmd)
      CMD_WRITE: begin
        new_bit = item_r.spin_value;
        acc     = 1'b0;
      end
      CMD_TRIAL: begin
        new_bit = (mode_r == MODE_GIBBS) ? !hit : (cur ^ hit);
        acc     = hit;
      end
      default: begin
        new_bit = cur;
        acc     = 1'b0;
      end
    endcase
    changed = (new_bit != cur);
    if (changed) begin
      mag_step = new_bit ? TWO : -TWO;
    end else begin
      mag_step = '0;
    end
    // The bond change is the spin change times the neighbour sum.
    if (changed && (slot != NSUM_ZERO)) begin
      bond_step = (new_bit == (slot == NSUM_POS)) ? FOUR : -FOUR;
    end else begin
      bond_step = '0;
    end
    bond_new = bond_r + bond_step;
    mag_new  = mag_r + mag_step;
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.commit) begin
      out_nxt.bad_site = bad_r;
      if (bad_r) begin
        out_nxt.new_spin     = 1'b0;
        out_nxt.accepted     = 1'b0;
        out_nxt.bond_total   = bond_r;
        out_nxt.magnet_total = mag_r;
      end else begin
        out_nxt.new_spin     = new_bit;
        out_nxt.accepted     = acc;
        out_nxt.bond_total   = bond_new;
        out_nxt.magnet_total = mag_new;
      end
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    len_nxt     = len_r;
    lim_up_nxt  = lim_up_r;
    lim_dn_nxt  = lim_dn_r;
    heat_nxt    = heat_r;
    bond_nxt    = bond_r;
    mag_nxt     = mag_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.commit && !bad_r) begin
      bond_nxt = bond_new;
      mag_nxt  = mag_new;
    end
    if (cmd.clr_start) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLER_MODE: mode_nxt = cfg_data[0];
        REG_RING_LENGTH: begin
          len_nxt  = len_sat;
          bond_nxt = $signed({1'b0, len_sat});
          mag_nxt  = $signed({1'b0, len_sat});
        end
        REG_FLIP_LIMITS_UP:   lim_up_nxt = cfg_data;
        REG_FLIP_LIMITS_DOWN: lim_dn_nxt = cfg_data;
        REG_HEAT_BATH_LIMITS: heat_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_METROPOLIS;
      len_r     <= LEN_RST;
      lim_up_r  <= '0;
      lim_dn_r  <= '0;
      heat_r    <= '0;
      bond_r    <= $signed({1'b0, LEN_RST});
      mag_r     <= $signed({1'b0, LEN_RST});
      clr_cnt_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      len_r     <= len_nxt;
      lim_up_r  <= lim_up_nxt;
      lim_dn_r  <= lim_dn_nxt;
      heat_r    <= heat_nxt;
      bond_r    <= bond_nxt;
      mag_r     <= mag_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_item;
      site_addr_r <= AW'(site_ext);
      bad_r       <= bad_in;
    end
    if (cmd.fetch) begin
      nl_r <= ra_data;
      nr_r <= rb_data;
    end
    out_r <= out_nxt;
  end

  assign out_item = out_r;

  // Port A reads the left neighbour on accept and the site itself afterwards.
  assign ra_addr = cmd.load ? AW'(left_l) : site_addr_r;
  assign rb_addr = AW'(right_l);
  assign we      = cmd.clr_step || (cmd.commit && !bad_r);
  assign waddr   = cmd.clr_step ? clr_cnt_r : site_addr_r;
  assign wdata   = cmd.clr_step ? 1'b1 : new_bit;

  isu_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SITES)
  ) u_spin_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

endmodule

// ----- hw/rtl/ising_1d_spin_update_core.sv -----
// An accepted transaction passes the fetch and execute states; its result is registered when
// the step commits, which waits while a held result is stalled. One item is worked on at a
// time, as the shared two-read-port spin memory serves neighbours, then site, then write-back.
// Reset (rst_n low, synchronous) and every ring_length write start a sweep over all
// MAX_SITES entries that sets all spins up; in_stall stays high during the sweep.
module ising_1d_spin_update_core
  import isu_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sta;

  isu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sta       (sta),
    .cmd       (cmd)
  );

  isu_dp #(
    .MAX_SITES (MAX_SITES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sta       (sta)
  );

endmodule

// ----- tb/sv/tb_ising_1d_spin_update_core.sv -----
`timescale 1ns / 1ps

module tb_ising_1d_spin_update_core;
  import isu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES = 13;
  localparam int ITEMS_PER_PHASE = 106;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  ising_1d_spin_update_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the ring, its running totals and the configuration.
  logic                   ring_spin [MAX_SITES_DEF];
  int                     bond_acc;
  int                     magnet_acc;
  int                     ring_len;
  logic                   mode_reg;
  logic [LIMIT_REG_W-1:0] lim_up;
  logic [LIMIT_REG_W-1:0] lim_down;
  logic [LIMIT_REG_W-1:0] lim_hb;

  in_item_t  spin_cmds[$];
  out_item_t expected_updates[$];

  bit steady = 1'b0;
  int mismatch_count = 0;
  int trial_count = 0;
  int accept_count = 0;
  int write_count = 0;
  int off_ring_count = 0;
  int ring_writes = 0;
  int feed_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic void fill_ring(input int len);
    for (int i = 0; i < MAX_SITES_DEF; i++) ring_spin[i] = 1'b1;
    ring_len = len;
    bond_acc = len;
    magnet_acc = len;
  endfunction

  // Applies one spin command to the shadow ring and returns the result it must produce.
  function automatic out_item_t predict_spin_update(input in_item_t it);
    out_item_t              r;
    int                     lft;
    int                     rgt;
    int                     nsum;
    int                     delta;
    logic                   cur;
    logic                   nxt;
    logic [LIMIT_W-1:0]     thr;
    logic [DRAW_W-1:0]      draw;
    logic [LIMIT_REG_W-1:0] lims;
    r = '0;
    draw = it.uniform_draw & DRAW_MASK;
    if (int'(it.site) >= ring_len) begin
      r.bad_site = 1'b1;
    end else begin
      lft = (it.site == 0) ? ring_len - 1 : int'(it.site) - 1;
      rgt = (int'(it.site) + 1 >= ring_len) ? 0 : int'(it.site) + 1;
      nsum = (ring_spin[lft] ? 1 : -1) + (ring_spin[rgt] ? 1 : -1);
      cur = ring_spin[it.site];
      nxt = cur;
      if (it.cmd == CMD_WRITE) begin
        nxt = it.spin_value;
      end else begin
        if (mode_reg == MODE_METROPOLIS) lims = cur ? lim_up : lim_down;
        else lims = lim_hb;
        // Slot 0, 1, 2 covers neighbour sums of -2, 0 and +2.
        thr = LIMIT_W'(lims >> (((nsum + 2) / 2) * LIMIT_W));
        if ({1'b0, draw} < thr) begin
          nxt = (mode_reg == MODE_METROPOLIS) ? ~cur : 1'b0;
          r.accepted = 1'b1;
        end else if (mode_reg == MODE_GIBBS) begin
          nxt = 1'b1;
        end
      end
      delta = (nxt ? 1 : -1) - (cur ? 1 : -1);
      bond_acc += delta * nsum;
      magnet_acc += delta;
      ring_spin[it.site] = nxt;
      r.new_spin = nxt;
    end
    r.bond_total = TOT_W'(bond_acc);
    r.magnet_total = TOT_W'(magnet_acc);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in steady phases.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LIMIT_W-1:0] limit_pick();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1ffff;
      3: return 17'd1;
      4: return 17'd65535;
      default: return LIMIT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [LIMIT_REG_W-1:0] limits_pick();
    return {limit_pick(), limit_pick(), limit_pick()};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] ring_length_pick();
    int choices [14] = '{0, 1, 2, 3, 4, 5, 8, 31, 64, 200, 1023, 1024, 1025, 2047};
    if ($urandom_range(0, 2) == 0) return CFG_DATA_W'($urandom_range(3, 40));
    return CFG_DATA_W'(choices[$urandom_range(0, 13)]);
  endfunction

  // Draws cluster at the active thresholds so both sides of each compare are hit.
  function automatic logic [DRAW_W-1:0] draw_pick();
    logic [LIMIT_W-1:0]     t;
    logic [LIMIT_REG_W-1:0] lims;
    int                     r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) begin
      lims = (mode_reg == MODE_GIBBS) ? lim_hb : ($urandom_range(0, 1) ? lim_up : lim_down);
      t = LIMIT_W'(lims >> ($urandom_range(0, 2) * LIMIT_W));
      t = t - LIMIT_W'($urandom_range(0, 1));
      if (t > 17'd65535) t = 17'd65535;
      return t[DRAW_W-1:0];
    end
    return DRAW_W'($urandom);
  endfunction

  task automatic push_cmd(input logic cmd, input int site, input logic sv,
                          input logic [DRAW_W-1:0] draw);
    in_item_t it;
    it.cmd = cmd;
    it.site = SITE_W'(site);
    it.spin_value = sv;
    it.uniform_draw = draw;
    spin_cmds.push_back(it);
  endtask

  task automatic push_random_cmd();
    int r;
    int site;
    r = $urandom_range(0, 99);
    if (r < 70) site = $urandom_range(0, ring_len - 1);
    else if (r < 80) site = $urandom_range(0, 1) ? 0 : ring_len - 1;
    else site = $urandom_range(0, MAX_SITES_DEF - 1);
    push_cmd($urandom_range(0, 99) < 60 ? CMD_TRIAL : CMD_WRITE, site,
             1'($urandom_range(0, 1)), draw_pick());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    int len;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLER_MODE: mode_reg = val[0];
      REG_RING_LENGTH: begin
        len = int'(val[LEN_W-1:0]);
        if (len < LEN_MIN) len = LEN_MIN;
        if (len > MAX_SITES_DEF) len = MAX_SITES_DEF;
        fill_ring(len);
        ring_writes++;
      end
      REG_FLIP_LIMITS_UP: lim_up = val;
      REG_FLIP_LIMITS_DOWN: lim_down = val;
      REG_HEAT_BATH_LIMITS: lim_hb = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (!(spin_cmds.size() == 0 && !in_valid && expected_updates.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Input side: presents queued commands and predicts each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_updates.push_back(predict_spin_update(in_item));
        if (in_item.cmd == CMD_TRIAL) trial_count++;
        else write_count++;
        if (int'(in_item.site) >= ring_len) off_ring_count++;
        if (expected_updates[$].accepted) accept_count++;
      end
      if (!(in_valid && in_stall)) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (spin_cmds.size() > 0) begin
          in_item <= spin_cmds.pop_front();
          in_valid <= 1'b1;
          feed_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure and field-by-field checking.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_updates.size() == 0) begin
          $error("result transaction arrived with nothing outstanding");
          mismatch_count++;
        end else begin
          exp_r = expected_updates.pop_front();
          compare_field("new_spin", int'(exp_r.new_spin), int'(out_item.new_spin));
          compare_field("accepted", int'(exp_r.accepted), int'(out_item.accepted));
          compare_field("bond_total", int'(exp_r.bond_total), int'(out_item.bond_total));
          compare_field("magnet_total", int'(exp_r.magnet_total),
                        int'(out_item.magnet_total));
          compare_field("bad_site", int'(exp_r.bad_site), int'(out_item.bad_site));
        end
      end
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog; its limit covers the clearing sweep after reset and each ring length write.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mode_reg = MODE_METROPOLIS;
    lim_up = '0;
    lim_down = '0;
    lim_hb = '0;
    fill_ring(LEN_RESET_DEF);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: full ring, Metropolis, every threshold zero.
    push_cmd(CMD_TRIAL, 0, 1'b0, 16'h0000);
    push_cmd(CMD_WRITE, 1023, 1'b0, 16'hffff);
    push_cmd(CMD_WRITE, 0, 1'b0, 16'h0000);
    push_cmd(CMD_WRITE, 1, 1'b1, 16'h1234);
    push_cmd(CMD_TRIAL, 1023, 1'b1, 16'hffff);
    push_cmd(CMD_TRIAL, 512, 1'b0, 16'h0000);
    wait_idle();

    // Ring length of zero saturates to the smallest ring.
    write_reg(REG_RING_LENGTH, '0);
    write_reg(REG_SAMPLER_MODE, CFG_DATA_W'(MODE_METROPOLIS));
    write_reg(REG_FLIP_LIMITS_UP, {3{17'd65536}});
    write_reg(REG_FLIP_LIMITS_DOWN, {17'd1, 17'd65536, 17'd0});
    write_reg(REG_HEAT_BATH_LIMITS, {17'd65536, 17'd0, 17'd32768});
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 51'h5a5a5);
    push_cmd(CMD_TRIAL, 0, 1'b1, 16'hffff);
    push_cmd(CMD_TRIAL, 0, 1'b0, 16'h0000);
    push_cmd(CMD_TRIAL, 3, 1'b0, 16'h0000);
    push_cmd(CMD_WRITE, 1023, 1'b0, 16'h0000);
    push_cmd(CMD_WRITE, 2, 1'b0, 16'h8000);
    push_cmd(CMD_TRIAL, 1, 1'b1, 16'h0000);
    push_cmd(CMD_WRITE, 0, 1'b0, 16'hffff);
    wait_idle();

    // Ring length above the maximum saturates; heat bath with saturated limits.
    write_reg(REG_SAMPLER_MODE, CFG_DATA_W'(MODE_GIBBS));
    write_reg(REG_RING_LENGTH, 51'd2047);
    write_reg(REG_HEAT_BATH_LIMITS, '1);
    push_cmd(CMD_TRIAL, 5, 1'b1, 16'hffff);
    push_cmd(CMD_WRITE, 6, 1'b0, 16'h0000);
    push_cmd(CMD_TRIAL, 7, 1'b0, 16'h0000);
    push_cmd(CMD_TRIAL, 1023, 1'b0, 16'h7fff);
    wait_idle();
    write_reg(REG_HEAT_BATH_LIMITS, '0);
    push_cmd(CMD_TRIAL, 5, 1'b0, 16'h0000);
    push_cmd(CMD_TRIAL, 6, 1'b1, 16'hffff);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady = (p % 4 == 3);
      write_reg(REG_SAMPLER_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      if (p < 4 || $urandom_range(0, 1) == 1) write_reg(REG_RING_LENGTH, ring_length_pick());
      write_reg(REG_FLIP_LIMITS_UP, limits_pick());
      write_reg(REG_FLIP_LIMITS_DOWN, limits_pick());
      write_reg(REG_HEAT_BATH_LIMITS, limits_pick());
      for (int k = 0; k < ITEMS_PER_PHASE; k++) push_random_cmd();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("checked %0d spin writes and %0d trials (%0d accepted), %0d off the ring",
             write_count, trial_count, accept_count, off_ring_count);
    $display("both samplers, %0d ring length settings, random thresholds and back-pressure",
             ring_writes);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/isu_pkg.sv
hw/rtl/isu_ram.sv
hw/rtl/isu_ctrl.sv
hw/rtl/isu_dp.sv
hw/rtl/ising_1d_spin_update_core.sv
tb/sv/tb_ising_1d_spin_update_core.sv
